FILE: hw/rtl/mspf_pkg.sv
// Package: shared types, constants and register codes of the speed controller.
`timescale 1ns / 1ps

package mspf_pkg;

    // Command clamp in whole duty counts
    localparam int DUTY_MAX = 255;

    // Field and state widths
    localparam int SP_W     = 15;
    localparam int GAIN_W   = 16;
    localparam int ILIM_W   = 20;
    localparam int TICK_W   = 10;
    localparam int ACC_W    = 16;
    localparam int RPM_W    = 32;
    localparam int ERR_W    = 33;
    localparam int ISUM_W   = 40;
    localparam int ITRIAL_W = 41;
    localparam int PD_W     = 50;
    localparam int FF_W     = 31;
    localparam int WIDE_W   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int MEAS_W   = 24;
    localparam int DUTY_W   = 8;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 41;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Command limit, Q.24
    localparam logic signed [WIDE_W-1:0] CMD_LIM = WIDE_W'(DUTY_MAX) <<< 24;

    // Measured speed saturation limits, Q.8
    localparam logic signed [RPM_W-1:0] MEAS_MAX = RPM_W'((64'sd1 <<< (MEAS_W - 1)) - 1);
    localparam logic signed [RPM_W-1:0] MEAS_MIN = -(RPM_W'(64'sd1 <<< (MEAS_W - 1)));

    // Register reset values
    localparam logic signed [SP_W-1:0]   RST_SETPOINT  = '0;
    localparam logic signed [GAIN_W-1:0] RST_KP        = 16'sd102;
    localparam logic [GAIN_W-1:0]        RST_KI        = 16'd1245;
    localparam logic signed [GAIN_W-1:0] RST_KD        = '0;
    localparam logic signed [GAIN_W-1:0] RST_KF        = 16'sd128;
    localparam logic [GAIN_W-1:0]        RST_RPP       = 16'd3636;
    localparam logic [ILIM_W-1:0]        RST_ILIM      = 20'd10000;
    localparam logic [TICK_W-1:0]        RST_SAMPLE_MS = 10'd20;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_KP        = 3'd1,
        REG_KI        = 3'd2,
        REG_KD        = 3'd3,
        REG_KF        = 3'd4,
        REG_RPP       = 3'd5,
        REG_ILIM      = 3'd6,
        REG_SAMPLE_MS = 3'd7
    } t_reg_idx;

    // Sequencer states, one per control update step
    typedef enum logic [3:0] {
        S_IDLE,
        S_RPM,
        S_ERR,
        S_PROP,
        S_DERIV,
        S_INTEG,
        S_TRIAL,
        S_OUTI,
        S_CMD
    } t_state;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_RPM,
        MUL_FF,
        MUL_P,
        MUL_D,
        MUL_ITRIAL,
        MUL_IOUT
    } t_mul_op;

    // Step controls from the sequencer to the datapath
    typedef struct packed {
        logic    busy;
        logic    ld_err;
        logic    ld_prop;
        logic    ld_deriv;
        logic    ld_integ;
        logic    ld_trial;
        logic    ld_base;
        logic    commit;
        t_mul_op mul_op;
    } t_ctrl;

endpackage

FILE: hw/rtl/mspf_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module mspf_mul
    import mspf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [MUL_A_W-1:0]  i_a,
    input  logic signed [MUL_B_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    // One multiply per cycle, result held until the next enabled step
    always_comb begin
        n_prod = PROD_W'(i_a) * PROD_W'(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: hw/rtl/mspf_seq.sv
// Sequencer that steps the shared multiplier through one control update.
`timescale 1ns / 1ps

module mspf_seq
    import mspf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_slot_free,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_RPM;
            S_RPM:   n_state = S_ERR;
            S_ERR:   n_state = S_PROP;
            S_PROP:  n_state = S_DERIV;
            S_DERIV: n_state = S_INTEG;
            S_INTEG: n_state = S_TRIAL;
            S_TRIAL: n_state = S_OUTI;
            S_OUTI:  n_state = S_CMD;
            S_CMD:   if (i_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Step controls
    always_comb begin
        o_ctrl        = '0;
        o_ctrl.busy   = (r_state != S_IDLE);
        o_ctrl.mul_op = MUL_IOUT;
        unique case (r_state)
            S_IDLE:  o_ctrl.mul_op = MUL_RPM;
            S_RPM:   o_ctrl.mul_op = MUL_RPM;
            S_ERR: begin
                o_ctrl.ld_err = 1'b1;
                o_ctrl.mul_op = MUL_FF;
            end
            S_PROP: begin
                o_ctrl.ld_prop = 1'b1;
                o_ctrl.mul_op  = MUL_P;
            end
            S_DERIV: begin
                o_ctrl.ld_deriv = 1'b1;
                o_ctrl.mul_op   = MUL_D;
            end
            S_INTEG: begin
                o_ctrl.ld_integ = 1'b1;
                o_ctrl.mul_op   = MUL_ITRIAL;
            end
            S_TRIAL: o_ctrl.ld_trial = 1'b1;
            S_OUTI:  o_ctrl.ld_base  = 1'b1;
            S_CMD:   o_ctrl.commit   = i_slot_free;
            default: o_ctrl.mul_op   = MUL_IOUT;
        endcase
    end

endmodule

FILE: hw/rtl/motor_speed_pid_with_feedforward.sv
// Top level: motor speed PID with feed-forward and conditional integration.
// Latency: a tick that closes no sample period is taken with no result.
// A tick that closes the period steps the sequencer through RPM, ERR, PROP, DERIV,
// INTEG, TRIAL, OUTI and CMD; input stall stays high for those 8 update steps, set by the sequencer.
// Throughput: one tick per cycle between updates; the last update step waits
// while the previous result is not taken. Reset: synchronous active low;
// registers to defaults, counters and sums to zero.
`timescale 1ns / 1ps

module motor_speed_pid_with_feedforward
    import mspf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // tick request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_pulse_count,
    // result request channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_reverse,
    output logic [DUTY_W-1:0]      o_duty,
    output logic signed [MEAS_W-1:0] o_measured_rpm,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers
    logic signed [SP_W-1:0]   r_setpoint;
    logic signed [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0]        r_ki;
    logic signed [GAIN_W-1:0] r_kd;
    logic signed [GAIN_W-1:0] r_kf;
    logic [GAIN_W-1:0]        r_rpp;
    logic [ILIM_W-1:0]        r_ilim;
    logic [TICK_W-1:0]        r_sample_ms;

    // Controller state
    logic [TICK_W-1:0]          r_tick_cnt;
    logic signed [ACC_W-1:0]    r_pulse_acc;
    logic signed [RPM_W-1:0]    r_prev;
    logic signed [ISUM_W-1:0]   r_isum;

    // Update working registers
    logic signed [RPM_W-1:0]    r_rpm;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [FF_W-1:0]     r_ff;
    logic signed [ERR_W-1:0]    r_diff;
    logic signed [PD_W-1:0]     r_pd;
    logic signed [ITRIAL_W-1:0] r_itrial;
    logic signed [WIDE_W-1:0]   r_base;

    // Output register
    logic                       r_out_valid;
    logic                       r_reverse;
    logic [DUTY_W-1:0]          r_duty;
    logic signed [MEAS_W-1:0]   r_meas;

    t_ctrl                      w_ctrl;
    logic                       w_in_acc;
    logic                       w_slot_free;
    logic [TICK_W-1:0]          w_cnt_inc;
    logic [TICK_W-1:0]          w_period;
    logic                       w_update;
    logic signed [ACC_W-1:0]    n_pulse_acc;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [RPM_W-1:0]    w_prod_rpm;
    logic signed [WIDE_W-1:0]   w_trial;
    logic                       w_win;
    logic signed [ITRIAL_W-1:0] w_ilim;
    logic signed [ITRIAL_W-1:0] w_iclamp;
    logic signed [WIDE_W-1:0]   w_cmd;
    logic signed [WIDE_W-1:0]   w_cmd_c;
    logic signed [WIDE_W-1:0]   w_mag;
    logic signed [RPM_W-1:0]    w_meas;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_ctrl.busy;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Tick bookkeeping: edge accumulation and period check
    always_comb begin
        w_cnt_inc = r_tick_cnt + TICK_W'(1);
        w_period  = (r_sample_ms == '0) ? TICK_W'(1) : r_sample_ms;
        w_update  = (w_cnt_inc >= w_period);
        if (r_setpoint[SP_W-1]) begin
            n_pulse_acc = r_pulse_acc - $signed({8'd0, i_pulse_count});
        end else begin
            n_pulse_acc = r_pulse_acc + $signed({8'd0, i_pulse_count});
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= RST_SETPOINT;
            r_kp        <= RST_KP;
            r_ki        <= RST_KI;
            r_kd        <= RST_KD;
            r_kf        <= RST_KF;
            r_rpp       <= RST_RPP;
            r_ilim      <= RST_ILIM;
            r_sample_ms <= RST_SAMPLE_MS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SETPOINT:  r_setpoint  <= $signed(i_cfg_data[SP_W-1:0]);
                REG_KP:        r_kp        <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_KI:        r_ki        <= i_cfg_data[GAIN_W-1:0];
                REG_KD:        r_kd        <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_KF:        r_kf        <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_RPP:       r_rpp       <= i_cfg_data[GAIN_W-1:0];
                REG_ILIM:      r_ilim      <= i_cfg_data[ILIM_W-1:0];
                REG_SAMPLE_MS: r_sample_ms <= i_cfg_data[TICK_W-1:0];
                default:       r_sample_ms <= r_sample_ms;
            endcase
        end
    end

    // Sequencer and shared multiplier
    mspf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_acc && w_update),
        .i_slot_free (w_slot_free),
        .o_ctrl      (w_ctrl)
    );

    // Operand selection for the current step
    always_comb begin
        unique case (w_ctrl.mul_op)
            MUL_RPM: begin
                w_mul_a = $signed({1'b0, r_rpp});
                w_mul_b = MUL_B_W'(r_pulse_acc);
            end
            MUL_FF: begin
                w_mul_a = MUL_A_W'(r_kf);
                w_mul_b = MUL_B_W'(r_setpoint);
            end
            MUL_P: begin
                w_mul_a = MUL_A_W'(r_kp);
                w_mul_b = MUL_B_W'(r_err);
            end
            MUL_D: begin
                w_mul_a = MUL_A_W'(r_kd);
                w_mul_b = MUL_B_W'(r_diff);
            end
            MUL_ITRIAL: begin
                w_mul_a = $signed({1'b0, r_ki});
                w_mul_b = r_itrial;
            end
            MUL_IOUT: begin
                w_mul_a = $signed({1'b0, r_ki});
                w_mul_b = MUL_B_W'(r_isum);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mspf_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.busy),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Trial command, integral clamp and final command
    always_comb begin
        w_prod_rpm = w_prod[RPM_W-1:0];
        w_trial    = (WIDE_W'(r_pd) <<< 8) + WIDE_W'(w_prod);
        w_win      = (w_trial < CMD_LIM) && (w_trial > -CMD_LIM);
        w_ilim     = $signed({13'd0, r_ilim, 8'd0});
        if (r_itrial > w_ilim) begin
            w_iclamp = w_ilim;
        end else if (r_itrial < -w_ilim) begin
            w_iclamp = -w_ilim;
        end else begin
            w_iclamp = r_itrial;
        end
        w_cmd = r_base + WIDE_W'(w_prod);
        if (w_cmd > CMD_LIM) begin
            w_cmd_c = CMD_LIM;
        end else if (w_cmd < -CMD_LIM) begin
            w_cmd_c = -CMD_LIM;
        end else begin
            w_cmd_c = w_cmd;
        end
        w_mag = w_cmd_c[WIDE_W-1] ? -w_cmd_c : w_cmd_c;
        if (r_rpm > MEAS_MAX) begin
            w_meas = MEAS_MAX;
        end else if (r_rpm < MEAS_MIN) begin
            w_meas = MEAS_MIN;
        end else begin
            w_meas = r_rpm;
        end
    end

    // Update working registers, loaded step by step
    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_err) begin
            r_rpm <= w_prod_rpm;
            r_err <= (ERR_W'(r_setpoint) <<< 8) - ERR_W'(w_prod_rpm);
        end
        if (w_ctrl.ld_prop) begin
            r_ff   <= w_prod[FF_W-1:0];
            r_diff <= ERR_W'(r_prev) - ERR_W'(r_rpm);
        end
        if (w_ctrl.ld_deriv) begin
            r_pd     <= w_prod[PD_W-1:0];
            r_itrial <= ITRIAL_W'(r_isum) + ITRIAL_W'(r_err);
        end
        if (w_ctrl.ld_integ) begin
            r_pd <= r_pd + w_prod[PD_W-1:0];
        end
        if (w_ctrl.ld_base) begin
            r_base <= (WIDE_W'(r_ff) <<< 16) + (WIDE_W'(r_pd) <<< 8);
        end
    end

    // Controller state: tick counter, edge accumulator, history, integral
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt  <= '0;
            r_pulse_acc <= '0;
            r_prev      <= '0;
            r_isum      <= '0;
        end else begin
            if (w_ctrl.commit) begin
                r_tick_cnt  <= '0;
                r_pulse_acc <= '0;
                r_prev      <= r_rpm;
            end else if (w_in_acc) begin
                r_tick_cnt  <= w_cnt_inc;
                r_pulse_acc <= n_pulse_acc;
            end
            // conditional integration: only inside the command window
            if (w_ctrl.ld_trial && w_win) begin
                r_isum <= w_iclamp[ISUM_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.commit) begin
            r_reverse <= w_cmd_c[WIDE_W-1];
            r_duty    <= w_mag[31:24];
            r_meas    <= w_meas[MEAS_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reverse      = r_reverse;
    assign o_duty         = r_duty;
    assign o_measured_rpm = r_meas;

    // A result appears only from the final update step
    a_out_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.commit))
        else $error("result raised without an update commit");

    // Committing an update restarts the sample period
    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.commit |=> (r_tick_cnt == '0) && (r_pulse_acc == '0))
        else $error("tick counter or accumulator not cleared after update");

    // A freshly integrated sum lies within the configured limit
    a_isum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.ld_trial && w_win) |=>
            (ITRIAL_W'(r_isum) <= w_ilim) && (ITRIAL_W'(r_isum) >= -w_ilim))
        else $error("integral outside its limit after accumulation");

endmodule

FILE: verif/testbench.sv
// Testbench: random and directed ticks against a built-in predictor of the speed controller.
`timescale 1ns / 1ps

module testbench;
    import mspf_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int TOTAL_TICKS   = 1775;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int LONG_PHASE    = 3;

    typedef struct {
        logic [7:0]  pulses;
        int unsigned gap;
    } t_tick_req;

    typedef struct {
        logic              reverse;
        logic [DUTY_W-1:0] duty;
        logic [MEAS_W-1:0] meas;
    } t_motor_cmd;

    // DUT ports, all inputs known from time zero
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [7:0]              i_pulse_count = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_reverse;
    logic [DUTY_W-1:0]       o_duty;
    logic signed [MEAS_W-1:0] o_measured_rpm;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    motor_speed_pid_with_feedforward dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow registers
    longint sp_rpm, kp, ki, kd, kf, rpp, ilim, ticks_per_sample;
    // Shadow loop state
    logic [TICK_W-1:0]       tick_cnt;
    logic signed [ACC_W-1:0] edge_acc;
    longint                  last_rpm;
    longint                  isum;

    t_tick_req  tick_queue[$];
    t_motor_cmd expected_cmds[$];
    t_tick_req  cur_tick;
    logic       loaded = 1'b0;
    logic       next_valid;
    int         items_queued = 0;
    int         ticks_taken = 0;
    int         results_seen = 0;
    int         err_count = 0;
    int         cycle_count = 0;
    int unsigned rx_wait = 0;
    logic       rx_idle_on = 1'b1;
    logic       hold_req = 1'b0;
    logic       hold_ack = 1'b0;
    int         hold_left = 0;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_pulses();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(0, 255));
            3:       return 8'hFF;
            4:       return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 24));
        endcase
    endfunction

    // Random register value, extremes favored, magnitudes spread over all sizes
    function automatic logic [CFG_DATA_W-1:0] rand_field(int w, bit sgn);
        logic [31:0] mask, v;
        int k;
        mask = (32'd1 << w) - 1;
        case ($urandom_range(0, 9))
            0: v = sgn ? (32'd1 << (w - 1)) : 32'd0;
            1: v = sgn ? ((32'd1 << (w - 1)) - 1) : mask;
            2: v = '0;
            default: begin
                k = $urandom_range(1, sgn ? w - 1 : w);
                v = $urandom & ((32'd1 << k) - 1);
                if (sgn && $urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return CFG_DATA_W'(v & mask);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_reg_value(t_reg_idx idx);
        case (idx)
            REG_SETPOINT:        return rand_field(SP_W, 1'b1);
            REG_KP, REG_KD, REG_KF: return rand_field(GAIN_W, 1'b1);
            REG_KI, REG_RPP:     return rand_field(GAIN_W, 1'b0);
            REG_ILIM:            return rand_field(ILIM_W, 1'b0);
            default:             return CFG_DATA_W'($urandom_range(0, 24));
        endcase
    endfunction

    function automatic void apply_cfg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SETPOINT:  sp_rpm = longint'($signed(data[SP_W-1:0]));
            REG_KP:        kp = longint'($signed(data[GAIN_W-1:0]));
            REG_KI:        ki = longint'(data[GAIN_W-1:0]);
            REG_KD:        kd = longint'($signed(data[GAIN_W-1:0]));
            REG_KF:        kf = longint'($signed(data[GAIN_W-1:0]));
            REG_RPP:       rpp = longint'(data[GAIN_W-1:0]);
            REG_ILIM:      ilim = longint'(data[ILIM_W-1:0]);
            REG_SAMPLE_MS: ticks_per_sample = longint'(data[TICK_W-1:0]);
            default: ;
        endcase
    endfunction

    // One tick of the speed loop; queues the motor command when a sample period closes
    function automatic void predict_tick(logic [7:0] pulses);
        longint period, rpm, err, pd, trial, lim, cmd, mag;
        t_motor_cmd c;
        period = (ticks_per_sample == 0) ? 1 : ticks_per_sample;
        if (sp_rpm >= 0) edge_acc = edge_acc + ACC_W'(pulses);
        else             edge_acc = edge_acc - ACC_W'(pulses);
        tick_cnt = tick_cnt + TICK_W'(1);
        if (longint'(tick_cnt) < period) return;

        rpm   = longint'(edge_acc) * rpp;
        err   = sp_rpm * 256 - rpm;
        pd    = kp * err + kd * (last_rpm - rpm);
        trial = pd * 256 + ki * (isum + err);
        lim   = longint'(DUTY_MAX) << 24;
        // conditional integration: only while the trial command is inside the clamp
        if (trial < lim && trial > -lim)
            isum = clamp_range(isum + err, -ilim * 256, ilim * 256);
        cmd = kf * sp_rpm * 65536 + pd * 256 + ki * isum;
        cmd = clamp_range(cmd, -lim, lim);

        last_rpm = rpm;
        tick_cnt = '0;
        edge_acc = '0;

        c.reverse = (cmd < 0);
        mag       = c.reverse ? -cmd : cmd;
        c.duty    = DUTY_W'(mag >> 24);
        c.meas    = MEAS_W'(clamp_range(rpm, -8388608, 8388607));
        expected_cmds.push_back(c);
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s at result %0d: got %0d, want %0d",
                 what, results_seen, got, want);
        err_count++;
    endtask

    task automatic check_cmd();
        t_motor_cmd c;
        if (expected_cmds.size() == 0) begin
            flag_mismatch("unexpected result, duty", longint'(o_duty), 0);
        end else begin
            c = expected_cmds.pop_front();
            if (o_reverse !== c.reverse)
                flag_mismatch("reverse", longint'(o_reverse), longint'(c.reverse));
            if (o_duty !== c.duty)
                flag_mismatch("duty", longint'(o_duty), longint'(c.duty));
            if (o_measured_rpm !== c.meas)
                flag_mismatch("measured_rpm", longint'(o_measured_rpm),
                              longint'($signed(c.meas)));
        end
        results_seen++;
    endtask

    // Tick request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            loaded = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_tick(i_pulse_count);
                ticks_taken <= ticks_taken + 1;
            end
            next_valid = 1'b0;
            if (i_in_valid && o_in_stall) begin
                // stalled request holds its payload
                next_valid = 1'b1;
            end else begin
                if (!loaded && tick_queue.size() != 0) begin
                    cur_tick = tick_queue.pop_front();
                    loaded = 1'b1;
                end
                if (loaded) begin
                    if (cur_tick.gap != 0) begin
                        cur_tick.gap--;
                    end else begin
                        next_valid = 1'b1;
                        i_pulse_count <= cur_tick.pulses;
                        loaded = 1'b0;
                    end
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) check_cmd();
            if (rx_wait != 0)
                rx_wait--;
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
                rx_wait = pick_gap() + 1;
            i_out_stall <= (hold_left != 0) || (rx_wait != 0);
        end
    end

    // Long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_tick(input logic [7:0] p, input bit gaps_on);
        t_tick_req t;
        t.pulses = p;
        t.gap    = gaps_on ? pick_gap() : 0;
        tick_queue.push_back(t);
        items_queued++;
    endtask

    // Every request taken, every command seen, then let a no-result tick finish
    task automatic wait_drained();
        do @(posedge i_clk); while (ticks_taken != items_queued || expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int  len;
        int  phase_no;
        bit  gaps_on;
        bit  hold_phase;
        logic [CFG_DATA_W-1:0] period;

        sp_rpm = longint'(RST_SETPOINT);
        kp     = longint'(RST_KP);
        ki     = longint'(RST_KI);
        kd     = longint'(RST_KD);
        kf     = longint'(RST_KF);
        rpp    = longint'(RST_RPP);
        ilim   = longint'(RST_ILIM);
        ticks_per_sample = longint'(RST_SAMPLE_MS);
        tick_cnt = '0;
        edge_acc = '0;
        last_rpm = 0;
        isum     = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults straight out of reset
        for (int i = 0; i < 40; i++) queue_tick(pick_pulses(), 1'b1);
        wait_drained();

        // every tick updates (zero period), all gains at their extremes
        write_reg(REG_SAMPLE_MS, '0);
        write_reg(REG_SETPOINT, 20'h03FFF);
        write_reg(REG_KP, 20'h07FFF);
        write_reg(REG_KI, 20'h0FFFF);
        write_reg(REG_KD, 20'h08000);
        write_reg(REG_KF, 20'h08000);
        write_reg(REG_RPP, 20'h0FFFF);
        write_reg(REG_ILIM, 20'hFFFFF);
        queue_tick(8'h00, 1'b0);
        queue_tick(8'hFF, 1'b0);
        for (int b = 0; b < 8; b++) queue_tick(8'(1 << b), 1'b1);
        wait_drained();

        // opposite extremes, reverse direction counts down
        write_reg(REG_SETPOINT, 20'h04000);
        write_reg(REG_KP, 20'h08000);
        write_reg(REG_KI, '0);
        write_reg(REG_KD, 20'h07FFF);
        write_reg(REG_KF, 20'h07FFF);
        write_reg(REG_RPP, '0);
        write_reg(REG_ILIM, '0);
        write_reg(REG_SAMPLE_MS, 20'd1);
        queue_tick(8'hFF, 1'b0);
        queue_tick(8'hAA, 1'b0);
        queue_tick(8'h55, 1'b0);
        queue_tick(8'h00, 1'b0);
        wait_drained();

        // command just below zero: reverse with zero duty
        write_reg(REG_SETPOINT, 20'h07FFF);
        write_reg(REG_KP, 20'd1);
        write_reg(REG_KD, '0);
        write_reg(REG_KF, '0);
        for (int i = 0; i < 3; i++) queue_tick(8'($urandom_range(0, 255)), 1'b0);
        wait_drained();

        // period lowered below the count already reached
        write_reg(REG_SETPOINT, 20'd100);
        write_reg(REG_KP, 20'd102);
        write_reg(REG_RPP, 20'd3636);
        write_reg(REG_ILIM, 20'd10000);
        write_reg(REG_SAMPLE_MS, 20'd300);
        for (int i = 0; i < 5; i++) queue_tick(8'hFF, 1'b0);
        wait_drained();
        write_reg(REG_SAMPLE_MS, 20'd2);
        queue_tick(8'hFF, 1'b0);
        wait_drained();

        // random phases
        phase_no = 0;
        while (items_queued < TOTAL_TICKS) begin
            if (phase_no == LONG_PHASE) begin
                // longest period, heavy edge counts: accumulator wraps
                write_reg(REG_SETPOINT, rand_field(SP_W, 1'b1));
                write_reg(REG_RPP, rand_field(GAIN_W, 1'b0));
                write_reg(REG_SAMPLE_MS, 20'h003FF);
                rx_idle_on <= 1'b0;
                len = 1030;
                for (int i = 0; i < len; i++)
                    queue_tick(8'($urandom_range(200, 255)), 1'b0);
            end else begin
                hold_phase = (phase_no % 4 == 1);
                for (int i = 0; i < int'(REG_SAMPLE_MS); i++)
                    if ($urandom_range(0, 1) == 1)
                        write_reg(t_reg_idx'(i), rand_reg_value(t_reg_idx'(i)));
                case ($urandom_range(0, 9))
                    0:             period = '0;
                    1, 2, 3, 4, 5: period = CFG_DATA_W'($urandom_range(1, 4));
                    6, 7:          period = CFG_DATA_W'($urandom_range(5, 24));
                    default:       period = CFG_DATA_W'($urandom_range(25, 200));
                endcase
                if (hold_phase) period = CFG_DATA_W'($urandom_range(1, 3));
                if (hold_phase || $urandom_range(0, 9) < 7) write_reg(REG_SAMPLE_MS, period);
                gaps_on = ($urandom_range(0, 2) != 0);
                rx_idle_on <= ($urandom_range(0, 2) != 0);
                if (hold_phase) hold_req <= ~hold_req;
                len = hold_phase ? 80 : $urandom_range(20, 80);
                for (int i = 0; i < len; i++) queue_tick(pick_pulses(), gaps_on);
            end
            wait_drained();
            phase_no++;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
